[sv/date_string_parser_top_macros.svh]
// ----------------------------------------------------------------------------
// Date string parser assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DATE_STRING_PARSER_TOP_MACROS_SVH
`define DATE_STRING_PARSER_TOP_MACROS_SVH

// Condition that must hold at every clock edge
`define DSP_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Condition that must hold in the cycle after a trigger
`define DSP_ASSERT_NEXT(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) else $error(msg);

`endif

[sv/dsparse_pkg.sv]
// ----------------------------------------------------------------------------
// Date string parser package
// Beat types, status codes, register indexes and fixed constants.
// ----------------------------------------------------------------------------
package dsparse_pkg;

	// Input beat: one ASCII character of the string
	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
	} char_beat_t;

	// Result beat: calendar date or ordinal
	typedef struct packed {
		logic [1:0]  status;
		logic        is_ordinal;
		logic [15:0] year_out;
		logic [3:0]  month_out;
		logic [4:0]  day_out;
		logic [15:0] chapter_out;
		logic [15:0] order_out;
	} result_beat_t;

	// Status codes
	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_INVALID = 2'd1;
	localparam logic [1:0] STATUS_RANGE   = 2'd2;

	// Register map
	localparam int unsigned APB_ADDR_W = 5;
	localparam logic [2:0] REG_MONTH_FIRST = 3'd0;
	localparam logic [2:0] REG_YEAR_MIN    = 3'd1;
	localparam logic [2:0] REG_YEAR_MAX    = 3'd2;
	localparam logic [2:0] REG_CHAPTER_MAX = 3'd3;
	localparam logic [2:0] REG_ORDER_MAX   = 3'd4;

	// Register reset values
	localparam logic [15:0] YEAR_MIN_RST    = 16'd1900;
	localparam logic [15:0] YEAR_MAX_RST    = 16'd2199;
	localparam logic [15:0] CHAPTER_MAX_RST = 16'd1023;
	localparam logic [15:0] ORDER_MAX_RST   = 16'd1023;

	// Character codes
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_DOT   = 8'h2E;
	localparam logic [7:0] CHAR_DASH  = 8'h2D;
	localparam logic [7:0] CHAR_SLASH = 8'h2F;

	// Field limits and two-digit year window
	localparam logic [4:0]  MONTH_LAST   = 5'd12;
	localparam logic [5:0]  DAY_LAST     = 6'd31;
	localparam logic [6:0]  YEAR_SHORT   = 7'd100;
	localparam logic [4:0]  YEAR_PIVOT   = 5'd30;
	localparam logic [10:0] CENTURY_NEW  = 11'd2000;
	localparam logic [10:0] CENTURY_OLD  = 11'd1900;

	// Divisibility by 25: multiply by the inverse of 25 mod 2^16
	localparam logic [15:0] INV25       = 16'd23593;
	localparam logic [15:0] DIV25_LIMIT = 16'd2621;

endpackage

[sv/date_string_parser_top.sv]
// ----------------------------------------------------------------------------
// Date string parser
// Reads a date string one character per beat and, on the last character,
// returns a calendar date or a chapter/order ordinal with a status code.
// ----------------------------------------------------------------------------
// A result moves from the input register through s2 and s3 into the output register.
// Throughput: one character per cycle unless a last character waits for s2; the accumulator update is one stage.
// Three result slots (s2, s3, output) absorb a stalled result side.
// Reset (arst_n low, async) clears the fields, the error flag and all
// pipeline valids, and loads the register reset values.
`include "date_string_parser_top_macros.svh"

module date_string_parser_top #(
	parameter int unsigned ACC_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// character channel
	input  logic                                item_valid,
	output logic                                item_ready,
	input  dsparse_pkg::char_beat_t             item_data,
	// result channel
	output logic                                result_valid,
	input  logic                                result_ready,
	output dsparse_pkg::result_beat_t           result_data,
	// register port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [dsparse_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);

	localparam int unsigned CMP_W = (ACC_WIDTH > 16) ? ACC_WIDTH : 16;
	localparam logic [1:0] FIELD_TRAIL = 2'd3;
	localparam logic [1:0] FIELD_LAST  = 2'd2;
	// classification codes carried from s2 to s3
	localparam logic [1:0] KIND_INVALID = 2'd0;
	localparam logic [1:0] KIND_DATE    = 2'd1;
	localparam logic [1:0] KIND_ORD     = 2'd2;
	localparam logic [3:0] MONTH_FEB = 4'd2;
	localparam logic [3:0] MONTH_APR = 4'd4;
	localparam logic [3:0] MONTH_JUN = 4'd6;
	localparam logic [3:0] MONTH_SEP = 4'd9;
	localparam logic [3:0] MONTH_NOV = 4'd11;

	// ------------------------------------------------------------------
	// Register port
	// ------------------------------------------------------------------
	logic        month_first_q;
	logic [15:0] year_min_q;
	logic [15:0] year_max_q;
	logic [15:0] chapter_max_q;
	logic [15:0] order_max_q;
	logic [2:0]  reg_idx;
	logic        reg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign reg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			month_first_q <= 1'b0;
			year_min_q    <= dsparse_pkg::YEAR_MIN_RST;
			year_max_q    <= dsparse_pkg::YEAR_MAX_RST;
			chapter_max_q <= dsparse_pkg::CHAPTER_MAX_RST;
			order_max_q   <= dsparse_pkg::ORDER_MAX_RST;
		end else if (reg_wr) begin
			unique case (reg_idx)
				dsparse_pkg::REG_MONTH_FIRST: month_first_q <= pwdata[0];
				dsparse_pkg::REG_YEAR_MIN:    year_min_q    <= pwdata[15:0];
				dsparse_pkg::REG_YEAR_MAX:    year_max_q    <= pwdata[15:0];
				dsparse_pkg::REG_CHAPTER_MAX: chapter_max_q <= pwdata[15:0];
				dsparse_pkg::REG_ORDER_MAX:   order_max_q   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			dsparse_pkg::REG_MONTH_FIRST: prdata = {31'd0, month_first_q};
			dsparse_pkg::REG_YEAR_MIN:    prdata = {16'd0, year_min_q};
			dsparse_pkg::REG_YEAR_MAX:    prdata = {16'd0, year_max_q};
			dsparse_pkg::REG_CHAPTER_MAX: prdata = {16'd0, chapter_max_q};
			dsparse_pkg::REG_ORDER_MAX:   prdata = {16'd0, order_max_q};
			default:                      prdata = 32'd0;
		endcase
	end

	// ------------------------------------------------------------------
	// Handshake chain: each stage moves when the next one has room
	// ------------------------------------------------------------------
	logic s1_v_s1, s2_v_s2, s3_v_s3, result_valid_q;
	logic s1_go, s2_free, s2_move, s3_free, s3_move, out_free;
	logic [7:0] char_s1;
	logic       last_s1;

	assign out_free   = !result_valid_q || result_ready;
	assign s3_move    = s3_v_s3 && out_free;
	assign s3_free    = !s3_v_s3 || s3_move;
	assign s2_move    = s2_v_s2 && s3_free;
	assign s2_free    = !s2_v_s2 || s2_move;
	// characters that end no string need no downstream slot
	assign s1_go      = s1_v_s1 && (!last_s1 || s2_free);
	assign item_ready = !s1_v_s1 || s1_go;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_s1 <= 1'b0;
		end else if (item_valid && item_ready) begin
			s1_v_s1 <= 1'b1;
		end else if (s1_go) begin
			s1_v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			char_s1 <= item_data.char_code;
			last_s1 <= item_data.last_char;
		end
	end

	// ------------------------------------------------------------------
	// Field accumulators: per-character update
	// ------------------------------------------------------------------
	logic [ACC_WIDTH-1:0] field_acc_q [3];
	logic [1:0]           field_index_q;
	logic                 error_q;
	logic [ACC_WIDTH-1:0] acc_nxt [3];
	logic [1:0]           idx_nxt;
	logic                 err_nxt;
	logic [ACC_WIDTH-1:0] acc_cur;
	logic [ACC_WIDTH+3:0] acc_x10;
	logic [ACC_WIDTH-1:0] acc_sat;
	logic [3:0]           digit_val;
	logic                 is_digit, is_sep;

	always_comb begin
		unique case (field_index_q)
			2'd0:    acc_cur = field_acc_q[0];
			2'd1:    acc_cur = field_acc_q[1];
			2'd2:    acc_cur = field_acc_q[2];
			default: acc_cur = '0;
		endcase
		is_digit  = (char_s1 >= dsparse_pkg::CHAR_ZERO) && (char_s1 <= dsparse_pkg::CHAR_NINE);
		is_sep    = (char_s1 == dsparse_pkg::CHAR_DOT) || (char_s1 == dsparse_pkg::CHAR_DASH) ||
			(char_s1 == dsparse_pkg::CHAR_SLASH);
		digit_val = 4'(char_s1 - dsparse_pkg::CHAR_ZERO);
		// acc * 10 + digit as two shifts and two adds, saturated
		acc_x10   = ({4'd0, acc_cur} << 3) + ({4'd0, acc_cur} << 1) +
			{{ACC_WIDTH{1'b0}}, digit_val};
		acc_sat   = (|acc_x10[ACC_WIDTH+3:ACC_WIDTH]) ? '1 : acc_x10[ACC_WIDTH-1:0];

		acc_nxt = field_acc_q;
		idx_nxt = field_index_q;
		err_nxt = error_q;
		priority if (is_digit) begin
			if (field_index_q == FIELD_TRAIL) begin
				err_nxt = 1'b1;
			end else begin
				for (int i = 0; i < 3; i++) begin
					if (field_index_q == 2'(i)) acc_nxt[i] = acc_sat;
				end
			end
		end else if (char_s1 == dsparse_pkg::CHAR_SPACE) begin
			// a space closes a non-empty field, else it is skipped
			if (acc_cur != '0 && field_index_q != FIELD_TRAIL) idx_nxt = field_index_q + 2'd1;
		end else if (is_sep) begin
			if (acc_cur == '0 || field_index_q >= FIELD_LAST) err_nxt = 1'b1;
			else idx_nxt = field_index_q + 2'd1;
		end else begin
			err_nxt = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) field_acc_q[i] <= '0;
			field_index_q <= 2'd0;
			error_q       <= 1'b0;
		end else if (s1_go) begin
			if (last_s1) begin
				for (int i = 0; i < 3; i++) field_acc_q[i] <= '0;
				field_index_q <= 2'd0;
				error_q       <= 1'b0;
			end else begin
				field_acc_q   <= acc_nxt;
				field_index_q <= idx_nxt;
				error_q       <= err_nxt;
			end
		end
	end

	// Snapshot of the finished string
	logic [ACC_WIDTH-1:0] n0_s2, n1_s2, n2_s2;
	logic                 err_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v_s2 <= 1'b0;
		end else if (s1_go && last_s1) begin
			s2_v_s2 <= 1'b1;
		end else if (s2_move) begin
			s2_v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && last_s1) begin
			n0_s2  <= acc_nxt[0];
			n1_s2  <= acc_nxt[1];
			n2_s2  <= acc_nxt[2];
			err_s2 <= err_nxt;
		end
	end

	// ------------------------------------------------------------------
	// Field order and year windowing
	// ------------------------------------------------------------------
	logic [1:0]           kind_c;
	logic [ACC_WIDTH-1:0] year_c;
	logic [3:0]           month_c;
	logic [4:0]           day_c;
	logic                 le12_0, le31_0, le12_1, le31_1, le31_2;

	assign le12_0 = n0_s2 <= ACC_WIDTH'(dsparse_pkg::MONTH_LAST);
	assign le31_0 = n0_s2 <= ACC_WIDTH'(dsparse_pkg::DAY_LAST);
	assign le12_1 = n1_s2 <= ACC_WIDTH'(dsparse_pkg::MONTH_LAST);
	assign le31_1 = n1_s2 <= ACC_WIDTH'(dsparse_pkg::DAY_LAST);
	assign le31_2 = n2_s2 <= ACC_WIDTH'(dsparse_pkg::DAY_LAST);

	always_comb begin
		kind_c  = KIND_INVALID;
		month_c = 4'd0;
		day_c   = 5'd0;
		// two-digit years fall in a window around the century
		year_c  = n2_s2;
		if (n2_s2 < ACC_WIDTH'(dsparse_pkg::YEAR_SHORT)) begin
			year_c = (n2_s2 < ACC_WIDTH'(dsparse_pkg::YEAR_PIVOT)) ?
				n2_s2 + ACC_WIDTH'(dsparse_pkg::CENTURY_NEW) :
				n2_s2 + ACC_WIDTH'(dsparse_pkg::CENTURY_OLD);
		end
		priority if (err_s2) begin
			kind_c = KIND_INVALID;
		end else if (n2_s2 != '0) begin
			kind_c = KIND_DATE;
			priority if (!le31_0 && le12_1 && le31_2) begin
				// year first
				year_c  = n0_s2;
				month_c = n1_s2[3:0];
				day_c   = n2_s2[4:0];
			end else if (le12_0 && le12_1) begin
				month_c = month_first_q ? n0_s2[3:0] : n1_s2[3:0];
				day_c   = month_first_q ? {1'b0, n1_s2[3:0]} : {1'b0, n0_s2[3:0]};
			end else if (le31_0 && le12_1) begin
				day_c   = n0_s2[4:0];
				month_c = n1_s2[3:0];
			end else if (le12_0 && le31_1) begin
				month_c = n0_s2[3:0];
				day_c   = n1_s2[4:0];
			end else begin
				kind_c = KIND_INVALID;
			end
		end else if (n1_s2 != '0) begin
			kind_c = KIND_ORD;
		end else begin
			kind_c = KIND_INVALID;
		end
	end

	logic [1:0]           kind_s3;
	logic [ACC_WIDTH-1:0] year_s3, ch_s3, od_s3;
	logic [3:0]           month_s3;
	logic [4:0]           day_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s3_v_s3 <= 1'b0;
		end else if (s3_free) begin
			s3_v_s3 <= s2_v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_move) begin
			kind_s3  <= kind_c;
			year_s3  <= year_c;
			month_s3 <= month_c;
			day_s3   <= day_c;
			ch_s3    <= n0_s2;
			od_s3    <= n1_s2;
		end
	end

	// ------------------------------------------------------------------
	// Range and calendar checks, result register
	// ------------------------------------------------------------------
	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		unique case (m)
			MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
			MONTH_FEB: len = leap ? 5'd29 : 5'd28;
			default:   len = 5'd31;
		endcase
		return len;
	endfunction

	logic [CMP_W-1:0] year_w, ch_w, od_w;
	logic [15:0]      year16, mod_prod;
	logic             div25, leap;
	dsparse_pkg::result_beat_t result_c, result_q;

	assign year_w   = CMP_W'(year_s3);
	assign ch_w     = CMP_W'(ch_s3);
	assign od_w     = CMP_W'(od_s3);
	assign year16   = year_w[15:0];
	// y divisible by 25 exactly when y * inv(25) mod 2^16 <= 65535 / 25
	assign mod_prod = 16'(year16 * dsparse_pkg::INV25);
	assign div25    = mod_prod <= dsparse_pkg::DIV25_LIMIT;
	assign leap     = (year16[1:0] == 2'd0) && (!div25 || year16[3:0] == 4'd0);

	always_comb begin
		result_c        = '0;
		result_c.status = dsparse_pkg::STATUS_INVALID;
		unique case (kind_s3)
			KIND_DATE: begin
				priority if (year_w < CMP_W'(year_min_q) || year_w > CMP_W'(year_max_q)) begin
					result_c.status = dsparse_pkg::STATUS_RANGE;
				end else if (month_s3 == 4'd0 || month_s3 > dsparse_pkg::MONTH_LAST[3:0] ||
					day_s3 == 5'd0 || day_s3 > month_len(month_s3, leap)) begin
					result_c.status = dsparse_pkg::STATUS_INVALID;
				end else begin
					result_c.status    = dsparse_pkg::STATUS_OK;
					result_c.year_out  = year16;
					result_c.month_out = month_s3;
					result_c.day_out   = day_s3;
				end
			end
			KIND_ORD: begin
				if (ch_w > CMP_W'(chapter_max_q) || od_w > CMP_W'(order_max_q)) begin
					result_c.status = dsparse_pkg::STATUS_RANGE;
				end else begin
					result_c.status      = dsparse_pkg::STATUS_OK;
					result_c.is_ordinal  = 1'b1;
					result_c.chapter_out = ch_w[15:0];
					result_c.order_out   = od_w[15:0];
				end
			end
			default: result_c.status = dsparse_pkg::STATUS_INVALID;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_free) begin
			result_valid_q <= s3_v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_move) result_q <= result_c;
	end

	assign result_valid = result_valid_q;
	assign result_data  = result_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`DSP_ASSERT_NEXT(a_clear_after_last, s1_go && last_s1, field_index_q == 2'd0 && !error_q && field_acc_q[0] == '0 && field_acc_q[1] == '0 && field_acc_q[2] == '0, "field state not cleared after last character")
	`DSP_ASSERT_ALWAYS(a_date_fields_legal, !(result_valid_q && result_q.status == dsparse_pkg::STATUS_OK && !result_q.is_ordinal) || (result_q.month_out != 4'd0 && result_q.month_out <= 4'd12 && result_q.day_out != 5'd0), "ok date with illegal month or day")
	`DSP_ASSERT_ALWAYS(a_fail_fields_zero, !(result_valid_q && result_q.status != dsparse_pkg::STATUS_OK) || (result_q.year_out == 16'd0 && result_q.chapter_out == 16'd0 && result_q.order_out == 16'd0 && !result_q.is_ordinal), "failed result carries nonzero fields")

endmodule
